/* design/fed_pkg.sv */
// ----------------------------------------------------------------------------
// fed_pkg - shared definitions for the feedback echo delay
// Sample and register widths, register indexes, reset values and defaults.
// ----------------------------------------------------------------------------
package fed_pkg;

    localparam int SAMPLE_W = 16;
    localparam int CFG_W    = 16;
    localparam int LEN_W    = 13;
    localparam int IDX_W    = 2;

    localparam int DEPTH_DEFAULT = 4096;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic [CFG_W-1:0]           gain_t;
    typedef logic [LEN_W-1:0]           len_t;
    typedef logic [IDX_W-1:0]           cfg_idx_t;

    localparam cfg_idx_t CFG_DELAY_LENGTH  = 2'd0;
    localparam cfg_idx_t CFG_FEEDBACK_GAIN = 2'd1;
    localparam cfg_idx_t CFG_MIX_GAIN      = 2'd2;

    localparam len_t  LEN_RESET      = 13'd1024;
    localparam gain_t FB_GAIN_RESET  = 16'd0;
    localparam gain_t MIX_GAIN_RESET = 16'd16384;
    localparam gain_t GAIN_ONE       = 16'h8000;

endpackage

/* design/feedback_echo_delay.sv */
// ----------------------------------------------------------------------------
// feedback_echo_delay - feedback comb echo on a 16-bit sample stream
// Delay store read one step ahead, gain and saturate in one pass, write back.
// ----------------------------------------------------------------------------
// One word is taken every cycle unless in_stall holds it off. The edge that
// accepts a word loads the delay store read register, and the edge on which
// that word leaves the read stage loads the result register, which drives
// sample_out; it waits while out_stall holds a result already on out_valid.
// Each word does one read and one write of the single-port-per-direction delay
// store, with the write of the word ahead forwarded when both hit the same
// entry. Entries never written read as zero through a fill count, so the block
// needs no clearing pass after reset and accepts words at once. Gains above
// 1.0 (32768) act as 1.0; a delay length of zero acts as 1 and one above DEPTH
// acts as DEPTH.
module feedback_echo_delay #(
    parameter int DEPTH = fed_pkg::DEPTH_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  fed_pkg::sample_t    sample_in,
    output logic                out_valid,
    input  logic                out_stall,
    output fed_pkg::sample_t    sample_out,
    input  logic                cfg_write,
    input  fed_pkg::cfg_idx_t   cfg_index,
    input  logic [fed_pkg::CFG_W-1:0] cfg_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LW = $clog2(DEPTH + 1);
    localparam int EW = (AW + 1 > fed_pkg::LEN_W) ? AW + 1 : fed_pkg::LEN_W;

    fed_pkg::len_t      dlen_reg;
    fed_pkg::gain_t     fb_gain_reg;
    fed_pkg::gain_t     mix_gain_reg;

    logic [AW-1:0]      pos_reg;
    logic [LW-1:0]      fill_reg;

    logic               s1_valid_reg;
    fed_pkg::sample_t   x_reg;
    logic [AW-1:0]      addr_reg;
    logic               ent_ok_reg;
    logic               fwd_reg;
    fed_pkg::sample_t   fwd_data_reg;
    fed_pkg::sample_t   mem_q_reg;

    logic               out_valid_reg;
    fed_pkg::sample_t   out_data_reg;

    fed_pkg::sample_t   store_mem [DEPTH];

    logic               accept;
    logic               s1_adv;
    logic [EW-1:0]      len_ext;
    logic [EW-1:0]      depth_ext;
    logic [EW-1:0]      eff_len;
    logic [EW-1:0]      pos_inc;
    logic [AW-1:0]      pos_next;
    logic               rd_ok;

    fed_pkg::sample_t   s_val;
    logic signed [32:0] mix_p;
    logic signed [32:0] fb_p;
    logic signed [32:0] mix_rnd;
    logic signed [32:0] fb_rnd;
    logic signed [16:0] mix_q;
    logic signed [16:0] fb_q;
    logic signed [17:0] y_sum;
    logic signed [17:0] st_sum;
    fed_pkg::sample_t   y_val;
    fed_pkg::sample_t   store_val;

    function automatic fed_pkg::sample_t sat16(input logic signed [17:0] v);
        fed_pkg::sample_t r;
        if (v > 18'sd32767)
        begin
            r = 16'sh7FFF;
        end
        else if (v < -18'sd32768)
        begin
            r = 16'sh8000;
        end
        else
        begin
            r = v[15:0];
        end
        return r;
    endfunction

    function automatic fed_pkg::gain_t lim_gain(input fed_pkg::gain_t g);
        return g[15] ? fed_pkg::GAIN_ONE : g;
    endfunction

    // handshake
    assign accept    = in_valid && !in_stall;
    assign s1_adv    = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = s1_valid_reg && !s1_adv;
    assign out_valid = out_valid_reg;
    assign sample_out = out_data_reg;

    // position wrap
    assign len_ext   = EW'(dlen_reg);
    assign depth_ext = EW'(DEPTH);
    assign eff_len   = (len_ext == '0) ? EW'(1) :
                       ((len_ext > depth_ext) ? depth_ext : len_ext);
    assign pos_inc   = EW'(pos_reg) + EW'(1);
    assign pos_next  = (pos_inc >= eff_len) ? '0 : pos_inc[AW-1:0];
    assign rd_ok     = LW'(pos_reg) < fill_reg;

    // gain, round and saturate
    assign s_val   = fwd_reg ? fwd_data_reg : (ent_ok_reg ? mem_q_reg : '0);
    assign mix_p   = $signed({1'b0, mix_gain_reg}) * s_val;
    assign fb_p    = $signed({1'b0, fb_gain_reg}) * s_val;
    assign mix_rnd = (mix_p + 33'sd16384) >>> 15;
    assign fb_rnd  = (fb_p + 33'sd16384) >>> 15;
    assign mix_q   = mix_rnd[16:0];
    assign fb_q    = fb_rnd[16:0];
    assign y_sum   = 18'(x_reg) + 18'(mix_q);
    assign st_sum  = 18'(x_reg) + 18'(fb_q);
    assign y_val   = sat16(y_sum);
    assign store_val = sat16(st_sum);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dlen_reg     <= fed_pkg::LEN_RESET;
            fb_gain_reg  <= fed_pkg::FB_GAIN_RESET;
            mix_gain_reg <= fed_pkg::MIX_GAIN_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                fed_pkg::CFG_DELAY_LENGTH:  dlen_reg     <= cfg_data[fed_pkg::LEN_W-1:0];
                fed_pkg::CFG_FEEDBACK_GAIN: fb_gain_reg  <= lim_gain(cfg_data);
                fed_pkg::CFG_MIX_GAIN:      mix_gain_reg <= lim_gain(cfg_data);
                default:                    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            fill_reg      <= '0;
            s1_valid_reg  <= 1'b0;
            ent_ok_reg    <= 1'b0;
            fwd_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                pos_reg    <= pos_next;
                ent_ok_reg <= rd_ok;
                fwd_reg    <= s1_adv && (addr_reg == pos_reg);
            end
            if (s1_adv && (LW'(addr_reg) >= fill_reg))
            begin
                fill_reg <= LW'(addr_reg) + LW'(1);
            end
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (!out_valid_reg || !out_stall)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_reg        <= sample_in;
            addr_reg     <= pos_reg;
            fwd_data_reg <= store_val;
        end
        if (s1_adv)
        begin
            out_data_reg <= y_val;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            store_mem[addr_reg] <= store_val;
        end
        if (accept)
        begin
            mem_q_reg <= store_mem[pos_reg];
        end
    end

`ifndef SYNTH
    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        LW'(pos_reg) < LW'(DEPTH))
        else $error("position outside delay store");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= LW'(DEPTH))
        else $error("fill count beyond delay store");

    a_pos_within_fill: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, fill_reg} + (LW + 1)'(s1_valid_reg)) >= (LW + 1)'(pos_reg))
        else $error("position ahead of written entries");

    a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_valid_reg)
        else $error("accepted word lost before result stage");

    a_fwd_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
        fwd_reg && !s1_valid_reg |-> !$past(accept))
        else $error("forward flag without word in flight");
`endif

endmodule
